// ===== src/bwm_pkg.sv =====
package bwm_pkg;

	localparam int MAX_PAYLOAD_DEF = 256;

	localparam logic [31:0] FLASH_LOW_RST  = 32'h0800_0000;
	localparam logic [31:0] FLASH_HIGH_RST = 32'h0807_FFFF;
	localparam logic [31:0] OPT_LOW_RST    = 32'h1FFF_C000;
	localparam logic [31:0] OPT_HIGH_RST   = 32'h1FFF_C00F;

	localparam logic [2:0] CFG_READ_PROTECT = 3'd0;
	localparam logic [2:0] CFG_FLASH_LOW    = 3'd1;
	localparam logic [2:0] CFG_FLASH_HIGH   = 3'd2;
	localparam logic [2:0] CFG_OPT_LOW      = 3'd3;
	localparam logic [2:0] CFG_OPT_HIGH     = 3'd4;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_NACK  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_LEN,
		ST_DATA,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic  frame_clr;
		logic  addr_clr;
		logic  addr_shift;
		logic  opt_load;
		logic  len_load;
		logic  data_store;
		logic  rd_start;
		logic  rd_issue;
		logic  rd_next;
		logic  out_load;
		kind_t out_kind;
	} bwm_cmd_t;

	typedef struct packed {
		logic read_protect;
		logic addr_full;
		logic addr_sum_ok;
		logic addr_ok;
		logic len_ok;
		logic data_full;
		logic data_sum_ok;
		logic opt_target;
		logic last_word;
		logic out_free;
	} bwm_sts_t;

endpackage

// ===== src/bwm_ram.sv =====
module bwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bwm_ctrl.sv =====
module bwm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cmd,
	input  bwm_pkg::bwm_sts_t  sts,
	output logic               in_stall,
	output bwm_pkg::bwm_cmd_t  ctl
);
	import bwm_pkg::*;

	state_t state_q, state_d;
	logic   in_fire;
	logic   rx_state;

	assign rx_state = (state_q == ST_IDLE) || (state_q == ST_ADDR) ||
		(state_q == ST_LEN) || (state_q == ST_DATA);
	assign in_stall = !rx_state || !sts.out_free;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.out_kind = KIND_ACK;
		if (in_fire && cmd == CMD_START) begin
			ctl.frame_clr = 1'b1;
			ctl.out_load  = 1'b1;
			if (sts.read_protect) begin
				ctl.out_kind = KIND_NACK;
				state_d      = ST_IDLE;
			end else begin
				ctl.addr_clr = 1'b1;
				state_d      = ST_ADDR;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
				end
				ST_ADDR: if (in_fire) begin
					if (!sts.addr_full) begin
						ctl.addr_shift = 1'b1;
					end else begin
						ctl.frame_clr = 1'b1;
						ctl.out_load  = 1'b1;
						if (sts.addr_sum_ok && sts.addr_ok) begin
							ctl.opt_load = 1'b1;
							state_d      = ST_LEN;
						end else begin
							ctl.out_kind = KIND_NACK;
							state_d      = ST_IDLE;
						end
					end
				end
				ST_LEN: if (in_fire) begin
					if (sts.len_ok) begin
						ctl.len_load = 1'b1;
						state_d      = ST_DATA;
					end else begin
						ctl.frame_clr = 1'b1;
						ctl.out_load  = 1'b1;
						ctl.out_kind  = KIND_NACK;
						state_d       = ST_IDLE;
					end
				end
				ST_DATA: if (in_fire) begin
					if (!sts.data_full) begin
						ctl.data_store = 1'b1;
					end else begin
						ctl.frame_clr = 1'b1;
						if (!sts.data_sum_ok) begin
							ctl.out_load = 1'b1;
							ctl.out_kind = KIND_NACK;
							state_d      = ST_IDLE;
						end else if (sts.opt_target) begin
							state_d = ST_IDLE;
						end else begin
							ctl.rd_start = 1'b1;
							state_d      = ST_READ;
						end
					end
				end
				ST_READ: begin
					ctl.rd_issue = 1'b1;
					state_d      = ST_EMIT;
				end
				ST_EMIT: if (sts.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_kind = KIND_WRITE;
					if (sts.last_word) begin
						state_d = ST_IDLE;
					end else begin
						ctl.rd_next = 1'b1;
						state_d     = ST_READ;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/bwm_dpath.sv =====
module bwm_dpath #(
	parameter int MAX_PAYLOAD = bwm_pkg::MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [7:0]         rx_byte,
	input  bwm_pkg::bwm_cmd_t  ctl,
	output bwm_pkg::bwm_sts_t  sts,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         kind,
	output logic [31:0]        write_address,
	output logic [31:0]        write_word,
	output logic [2:0]         valid_bytes,
	output logic               last
);
	import bwm_pkg::*;

	localparam int CW    = $clog2(MAX_PAYLOAD + 1);
	localparam int DEPTH = (MAX_PAYLOAD + 3) / 4;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

	logic        rp_q;
	logic [31:0] flash_low_q, flash_high_q, opt_low_q, opt_high_q;

	logic [CW-1:0] byte_count_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] len_m1;
	logic [31:0]   target_q;
	logic [7:0]    xor_q;
	logic          opt_q;
	logic [31:0]   asm_q, asm_d;
	logic [1:0]    lane;
	logic [IW-1:0] rd_idx_q;
	logic [8:0]    len_ext;
	logic          in_opt, in_flash;
	logic          ram_we;
	logic [31:0]   ram_rdata;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [31:0] addr_q, word_q;
	logic [2:0]  vb_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q         <= 1'b0;
			flash_low_q  <= FLASH_LOW_RST;
			flash_high_q <= FLASH_HIGH_RST;
			opt_low_q    <= OPT_LOW_RST;
			opt_high_q   <= OPT_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_READ_PROTECT: rp_q         <= cfg_data[0];
				CFG_FLASH_LOW:    flash_low_q  <= cfg_data;
				CFG_FLASH_HIGH:   flash_high_q <= cfg_data;
				CFG_OPT_LOW:      opt_low_q    <= cfg_data;
				CFG_OPT_HIGH:     opt_high_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign lane    = byte_count_q[1:0];
	assign asm_d   = ((lane == 2'd0) ? 32'd0 : asm_q) | (32'(rx_byte) << {lane, 3'b000});
	assign len_m1  = len_q - CW'(1);
	assign len_ext = {1'b0, rx_byte} + 9'd1;
	assign in_opt   = (target_q >= opt_low_q) && (target_q <= opt_high_q);
	assign in_flash = (target_q >= flash_low_q) && (target_q <= flash_high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			len_q        <= '0;
			target_q     <= '0;
			xor_q        <= '0;
			opt_q        <= 1'b0;
			rd_idx_q     <= '0;
		end else begin
			if (ctl.frame_clr) begin
				byte_count_q <= '0;
				xor_q        <= '0;
			end
			if (ctl.addr_clr) begin
				target_q <= '0;
			end
			if (ctl.addr_shift) begin
				target_q     <= {target_q[23:0], rx_byte};
				xor_q        <= xor_q ^ rx_byte;
				byte_count_q <= byte_count_q + CW'(1);
			end
			if (ctl.opt_load) begin
				opt_q <= in_opt;
			end
			if (ctl.len_load) begin
				len_q        <= CW'(len_ext);
				xor_q        <= rx_byte;
				byte_count_q <= '0;
			end
			if (ctl.data_store) begin
				xor_q        <= xor_q ^ rx_byte;
				byte_count_q <= byte_count_q + CW'(1);
			end
			if (ctl.rd_start) begin
				rd_idx_q <= '0;
			end
			if (ctl.rd_next) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.data_store) begin
			asm_q <= asm_d;
		end
	end

	assign ram_we = ctl.data_store && ((lane == 2'd3) || (byte_count_q == len_m1));

	bwm_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(byte_count_q >> 2)),
		.wdata (asm_d),
		.re    (ctl.rd_issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts              = '0;
		sts.read_protect = rp_q;
		sts.addr_full    = (byte_count_q == CW'(4));
		sts.addr_sum_ok  = (xor_q == rx_byte);
		sts.addr_ok      = in_opt || in_flash;
		sts.len_ok       = (len_ext <= MaxLen);
		sts.data_full    = (byte_count_q == len_q);
		sts.data_sum_ok  = (xor_q == rx_byte);
		sts.opt_target   = opt_q;
		sts.last_word    = (rd_idx_q == IW'(len_m1 >> 2));
		sts.out_free     = !out_valid_q || !out_stall;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			kind_q <= ctl.out_kind;
			if (ctl.out_kind == KIND_WRITE) begin
				addr_q <= target_q + (32'(rd_idx_q) << 2);
				word_q <= ram_rdata;
				vb_q   <= sts.last_word ? (3'(len_m1[1:0]) + 3'd1) : 3'd4;
				last_q <= sts.last_word;
			end else begin
				addr_q <= '0;
				word_q <= '0;
				vb_q   <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign write_address = addr_q;
	assign write_word    = word_q;
	assign valid_bytes   = vb_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> sts.out_free)
		else $error("result loaded over an unsent beat");

	a_reply_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_WRITE |-> last_q && vb_q == 3'd0)
		else $error("reply beat with word fields");

	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_WRITE |-> vb_q != 3'd0 && vb_q <= 3'd4)
		else $error("bad valid byte count");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.data_store |-> byte_count_q < len_q)
		else $error("payload store past frame length");
`endif

endmodule

// ===== src/boot_write_memory_frame_core.sv =====
// channel  direction  handshake            payload
// in       to core    in_valid / in_stall  cmd, rx_byte
// out      from core  out_valid/out_stall  kind, write_address, write_word, valid_bytes, last
// cfg      to core    cfg_we               cfg_index, cfg_data
//
// a byte or start beat per cycle unless in_stall; acks and nacks land in the result register
// a good flash frame drains ceil((N+1)/4) word writes, each a read then an emit state, as
// the payload word memory has a single registered read port; no input is taken meanwhile
// arst_n clears state and control; payload memory has no reset
// input stalls while draining or while a result waits and out_stall is high
module boot_write_memory_frame_core #(
	parameter int MAX_PAYLOAD = bwm_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] write_address,
	output logic [31:0] write_word,
	output logic [2:0]  valid_bytes,
	output logic        last
);
	import bwm_pkg::*;

	bwm_cmd_t ctl;
	bwm_sts_t sts;

	bwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	bwm_dpath #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.ctl           (ctl),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.write_address (write_address),
		.write_word    (write_word),
		.valid_bytes   (valid_bytes),
		.last          (last)
	);

endmodule
